// File: hdl/afr_pkg.sv
// Package for the 3D principal-axis frame rotation pipeline.
// Holds fixed-point constants, latency figures, the arctangent table and the request sideband type.
// No dependencies.
`default_nettype none
package afr_pkg;

    localparam int CORDIC_STEPS    = 24;
    localparam int COORD_FRAC_BITS = 16;
    localparam int STEP_W          = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

    localparam logic [33:0] HALF_PI_Q27    = 34'd210828714;
    localparam logic [33:0] QUARTER_PI_Q27 = 34'd105414357;
    localparam logic [34:0] ANGLE_OFFSET   = 35'd2635358925;
    localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;
    localparam logic signed [31:0] ONE_Q30         = 32'sd1073741824;

    localparam logic [1:0] AXIS_X   = 2'd0;
    localparam logic [1:0] AXIS_Y   = 2'd1;
    localparam logic [1:0] AXIS_Z   = 2'd2;
    localparam logic [1:0] AXIS_BAD = 2'd3;
    localparam logic       ACT_FWD  = 1'b0;

    localparam int QUOT_BITS   = 5;
    localparam int REDUCE_LAT  = QUOT_BITS + 2;
    localparam int XFORM_LAT   = 4;
    localparam int FRONT_LAT   = REDUCE_LAT + CORDIC_STEPS;
    localparam int TOTAL_LAT   = FRONT_LAT + XFORM_LAT;

    typedef struct packed {
        logic              action;
        logic [1:0]        axis;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        logic signed [31:0] tz;
    } side_t;

    // Arctangent of 2^-i in Q2.30
    function automatic logic signed [31:0] atan_entry(input logic [STEP_W-1:0] i);
        logic signed [31:0] r;
        begin
            r = 32'sd0;
            unique case (i)
                STEP_W'(0): r = 32'sd843314857;
                STEP_W'(1): r = 32'sd497837829;
                STEP_W'(2): r = 32'sd263043837;
                STEP_W'(3): r = 32'sd133525159;
                STEP_W'(4): r = 32'sd67021687;
                STEP_W'(5): r = 32'sd33543516;
                STEP_W'(6): r = 32'sd16775851;
                STEP_W'(7): r = 32'sd8388437;
                STEP_W'(8): r = 32'sd4194283;
                STEP_W'(9): r = 32'sd2097149;
                default:
                begin
                    if (32'(i) <= 32'd30)
                        r = 32'sd1 <<< (32'd30 - 32'(i));
                    else
                        r = 32'sd0;
                end
            endcase
            return r;
        end
    endfunction

endpackage
`default_nettype wire

// File: hdl/afr_reduce.sv
// Angle quadrant reduction: pipelined divide by pi/2, one quotient bit per stage.
// Depends on afr_pkg.
`default_nettype none
module afr_reduce (
    input  wire logic               clk,
    input  wire logic signed [31:0] angle,
    output logic signed [31:0]      z_out,
    output logic [1:0]              quad_out
);
    import afr_pkg::*;

    logic [33:0]          rem_reg  [0:QUOT_BITS];
    logic [QUOT_BITS-1:0] q_reg    [0:QUOT_BITS];
    logic signed [31:0]   z_reg;
    logic [1:0]           quad_reg;
    logic [34:0]          t_next;
    logic signed [29:0]   diff;
    logic signed [32:0]   zw;

    // Bias angle so it is always positive
    assign t_next = {{3{angle[31]}}, angle} + ANGLE_OFFSET;

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= t_next[33:0];
        q_reg[0]   <= '0;
    end

    // Restoring divide steps, highest multiple first
    for (genvar s = 0; s < QUOT_BITS; s++) begin : g_div
        logic [33:0] dv;
        assign dv = HALF_PI_Q27 << (QUOT_BITS - 1 - s);
        always_ff @(posedge clk)
        begin
            if (rem_reg[s] >= dv)
            begin
                rem_reg[s+1] <= rem_reg[s] - dv;
                q_reg[s+1]   <= q_reg[s] | (QUOT_BITS'(1) << (QUOT_BITS - 1 - s));
            end
            else
            begin
                rem_reg[s+1] <= rem_reg[s];
                q_reg[s+1]   <= q_reg[s];
            end
        end
    end

    // Center remainder and scale to Q2.30
    assign diff = $signed({1'b0, rem_reg[QUOT_BITS][28:0]}) - $signed(QUARTER_PI_Q27[29:0]);
    assign zw   = {diff, 3'b000};

    always_ff @(posedge clk)
    begin
        z_reg    <= zw[31:0];
        quad_reg <= q_reg[QUOT_BITS][1:0];
    end

    assign z_out    = z_reg;
    assign quad_out = quad_reg;
endmodule
`default_nettype wire

// File: hdl/afr_cordic_cell.sv
// One rotation-mode CORDIC iteration with output register.
// Depends on afr_pkg.
`default_nettype none
module afr_cordic_cell (
    input  wire logic                          clk,
    input  wire logic [afr_pkg::STEP_W-1:0]    step,
    input  wire logic signed [31:0]            x_in,
    input  wire logic signed [31:0]            y_in,
    input  wire logic signed [31:0]            z_in,
    input  wire logic [1:0]                    quad_in,
    output logic signed [31:0]                 x_out,
    output logic signed [31:0]                 y_out,
    output logic signed [31:0]                 z_out,
    output logic [1:0]                         quad_out
);
    import afr_pkg::*;

    logic signed [31:0] dx, dy, a;
    logic signed [31:0] x_reg, y_reg, z_reg;
    logic [1:0]         quad_reg;

    assign dx = y_in >>> step;
    assign dy = x_in >>> step;
    assign a  = atan_entry(step);

    // Rotate toward zero residual angle
    always_ff @(posedge clk)
    begin
        if (!z_in[31])
        begin
            x_reg <= x_in - dx;
            y_reg <= y_in + dy;
            z_reg <= z_in - a;
        end
        else
        begin
            x_reg <= x_in + dx;
            y_reg <= y_in - dy;
            z_reg <= z_in + a;
        end
        quad_reg <= quad_in;
    end

    assign x_out    = x_reg;
    assign y_out    = y_reg;
    assign z_out    = z_reg;
    assign quad_out = quad_reg;
endmodule
`default_nettype wire

// File: hdl/afr_transform.sv
// Matrix build, multiply, round, offset and saturate: four register stages.
// Depends on afr_pkg.
`default_nettype none
module afr_transform (
    input  wire logic               clk,
    input  wire logic signed [31:0] x_in,
    input  wire logic signed [31:0] y_in,
    input  wire logic [1:0]         quad_in,
    input  wire afr_pkg::side_t     side_in,
    output logic signed [31:0]      out_x,
    output logic signed [31:0]      out_y,
    output logic signed [31:0]      out_z,
    output logic                    axis_error
);
    import afr_pkg::*;

    logic signed [31:0] c, s;
    logic signed [31:0] m [0:2][0:2];
    logic signed [31:0] e [0:2][0:2];
    logic signed [32:0] v [0:2];
    logic signed [32:0] p33 [0:2];
    logic signed [32:0] t33 [0:2];

    logic signed [31:0] m_reg [0:2][0:2];
    logic signed [32:0] v_reg [0:2];
    side_t              s1_reg, s2_reg, s3_reg;
    logic signed [64:0] prod_reg [0:2][0:2];
    logic signed [66:0] acc_reg [0:2];
    logic signed [31:0] res_reg [0:2];
    logic               err_reg;

    // Map CORDIC result to cosine and sine by quadrant
    always_comb
    begin
        unique case (quad_in)
            2'd0:    begin c = x_in;  s = y_in;  end
            2'd1:    begin c = -y_in; s = x_in;  end
            2'd2:    begin c = -x_in; s = -y_in; end
            default: begin c = y_in;  s = -x_in; end
        endcase
    end

    // Build forward matrix for the axis
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                e[i][j] = '0;
        unique case (side_in.axis)
            AXIS_X:
            begin
                e[0][0] = ONE_Q30;
                e[1][1] = c;  e[1][2] = s;
                e[2][1] = -s; e[2][2] = c;
            end
            AXIS_Y:
            begin
                e[0][0] = c;  e[0][2] = -s;
                e[1][1] = ONE_Q30;
                e[2][0] = s;  e[2][2] = c;
            end
            default:
            begin
                e[0][0] = c;  e[0][1] = s;
                e[1][0] = -s; e[1][1] = c;
                e[2][2] = ONE_Q30;
            end
        endcase
    end

    // Pick matrix or its transpose and the operand vector
    always_comb
    begin
        p33[0] = 33'(side_in.px); p33[1] = 33'(side_in.py); p33[2] = 33'(side_in.pz);
        t33[0] = 33'(side_in.tx); t33[1] = 33'(side_in.ty); t33[2] = 33'(side_in.tz);
        for (int i = 0; i < 3; i++)
        begin
            v[i] = (side_in.action == ACT_FWD) ? (p33[i] - t33[i]) : p33[i];
            for (int j = 0; j < 3; j++)
                m[i][j] = (side_in.action == ACT_FWD) ? e[i][j] : e[j][i];
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg  <= m;
        v_reg  <= v;
        s1_reg <= side_in;
    end

    // Products
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                prod_reg[i][j] <= 65'(m_reg[i][j]) * 65'(v_reg[j]);
        s2_reg <= s1_reg;
    end

    // Row sums with rounding bias
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            acc_reg[i] <= 67'(prod_reg[i][0]) + 67'(prod_reg[i][1])
                        + 67'(prod_reg[i][2]) + (67'sd1 <<< 29);
        s3_reg <= s2_reg;
    end

    // Shift, add offset in inverse mode, saturate; zero the point on an invalid axis
    always_ff @(posedge clk)
    begin
        logic signed [36:0] sh;
        logic signed [37:0] fin;
        logic signed [31:0] toff [0:2];
        toff[0] = s3_reg.tx; toff[1] = s3_reg.ty; toff[2] = s3_reg.tz;
        for (int i = 0; i < 3; i++)
        begin
            sh  = 37'(acc_reg[i] >>> 30);
            fin = 38'(sh) + ((s3_reg.action == ACT_FWD) ? 38'sd0 : 38'(toff[i]));
            if (s3_reg.axis == AXIS_BAD)
                res_reg[i] <= '0;
            else if (fin > 38'sd2147483647)
                res_reg[i] <= 32'sh7FFFFFFF;
            else if (fin < -38'sd2147483648)
                res_reg[i] <= 32'sh80000000;
            else
                res_reg[i] <= fin[31:0];
        end
        err_reg <= (s3_reg.axis == AXIS_BAD);
    end

    assign out_x      = res_reg[0];
    assign out_y      = res_reg[1];
    assign out_z      = res_reg[2];
    assign axis_error = err_reg;
endmodule
`default_nettype wire

// File: hdl/axis_frame_rotation_3d.sv
// Top level of the 3D principal-axis rotation with translation pipeline.
// Depends on afr_pkg, afr_reduce, afr_cordic_cell, afr_transform.
//
//  Channel  | Marked by      | Fields
//  request  | start, !busy   | action axis angle point_x/y/z shift_x/y/z
//  result   | done           | out_x out_y out_z axis_error
//
// One request per cycle; busy is always low. A request passes 7 reduction stages,
// CORDIC_STEPS cells and 4 transform stages before done marks its result. The divide
// stages, the CORDIC cell row and the transform stages set the latency.
// Reset clears the valid chain only. The receiver cannot stall; done lasts one cycle.
`default_nettype none
module axis_frame_rotation_3d (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               action,
    input  wire logic [1:0]         axis,
    input  wire logic signed [31:0] angle,
    input  wire logic signed [31:0] point_x,
    input  wire logic signed [31:0] point_y,
    input  wire logic signed [31:0] point_z,
    input  wire logic signed [31:0] shift_x,
    input  wire logic signed [31:0] shift_y,
    input  wire logic signed [31:0] shift_z,
    output logic                    done,
    output logic signed [31:0]      out_x,
    output logic signed [31:0]      out_y,
    output logic signed [31:0]      out_z,
    output logic                    axis_error
);
    import afr_pkg::*;

    logic [TOTAL_LAT-1:0] vld_reg;
    side_t                side_reg [0:FRONT_LAT-1];
    side_t                side_in;
    logic signed [31:0]   cx [0:CORDIC_STEPS];
    logic signed [31:0]   cy [0:CORDIC_STEPS];
    logic signed [31:0]   cz [0:CORDIC_STEPS];
    logic [1:0]           cq [0:CORDIC_STEPS];

    assign busy = 1'b0;

    // Advance request valid marks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[TOTAL_LAT-2:0], start};
    end
    assign done = vld_reg[TOTAL_LAT-1];

    // Hold request sideband alongside the angle path
    assign side_in = '{action: action, axis: axis, px: point_x, py: point_y, pz: point_z,
                       tx: shift_x, ty: shift_y, tz: shift_z};

    always_ff @(posedge clk)
    begin
        side_reg[0] <= side_in;
        for (int k = 1; k < FRONT_LAT; k++)
            side_reg[k] <= side_reg[k-1];
    end

    afr_reduce u_reduce (
        .clk      (clk),
        .angle    (angle),
        .z_out    (cz[0]),
        .quad_out (cq[0])
    );

    assign cx[0] = CORDIC_GAIN_Q30;
    assign cy[0] = '0;

    // Row of CORDIC cells
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
        afr_cordic_cell u_cell (
            .clk      (clk),
            .step     (STEP_W'(i)),
            .x_in     (cx[i]),
            .y_in     (cy[i]),
            .z_in     (cz[i]),
            .quad_in  (cq[i]),
            .x_out    (cx[i+1]),
            .y_out    (cy[i+1]),
            .z_out    (cz[i+1]),
            .quad_out (cq[i+1])
        );
    end

    afr_transform u_xform (
        .clk        (clk),
        .x_in       (cx[CORDIC_STEPS]),
        .y_in       (cy[CORDIC_STEPS]),
        .quad_in    (cq[CORDIC_STEPS]),
        .side_in    (side_reg[FRONT_LAT-1]),
        .out_x      (out_x),
        .out_y      (out_y),
        .out_z      (out_z),
        .axis_error (axis_error)
    );
endmodule
`default_nettype wire

// File: hdl/afr_checker.sv
// Port-level checker for the frame rotation top level, with its bind.
// Depends on afr_pkg.
`default_nettype none
module afr_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic               done,
    input wire logic               axis_error,
    input wire logic signed [31:0] out_x,
    input wire logic signed [31:0] out_y,
    input wire logic signed [31:0] out_z
);
    import afr_pkg::*;

    // Every request yields a result after the fixed latency
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##TOTAL_LAT done)
        else $error("result missing after request");

    // No result without a matching request
    a_nospur: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, TOTAL_LAT))
        else $error("result without request");

    // Invalid axis gives a zero point
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        (done && axis_error) |-> (out_x == 32'sd0 && out_y == 32'sd0 && out_z == 32'sd0))
        else $error("nonzero point on axis error");
endmodule

bind axis_frame_rotation_3d afr_checker u_afr_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .axis_error (axis_error),
    .out_x      (out_x),
    .out_y      (out_y),
    .out_z      (out_z)
);
`default_nettype wire
